FILE: rtl/lpg_pkg.sv
// Shared constants and types of the line pixel generator.
package lpg_pkg;

	// Coordinate width and the widths derived from it.
	localparam int COORD_BITS = 16;
	localparam int DELTA_BITS = COORD_BITS + 1;
	localparam int ERR_BITS   = COORD_BITS + 4;
	localparam int COLOR_BITS = 32;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	// Request modes.
	localparam logic MODE_START   = 1'b0;
	localparam logic MODE_ADVANCE = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DELTA_BITS-1:0] delta_t;
	typedef logic        [DELTA_BITS-1:0] dist_t;
	typedef logic signed [ERR_BITS-1:0]   err_t;
	typedef logic        [COLOR_BITS-1:0] color_t;

	// Classified command handed from the front to the back.
	typedef struct packed {
		logic   start;
		logic   steep;
		logic   minor_neg;
		coord_t major_pos;
		coord_t major_stop;
		coord_t minor_pos;
		err_t   error_term;
		err_t   inc_straight;
		err_t   inc_diagonal;
		color_t color;
	} lpg_cmd_t;

endpackage

FILE: rtl/lpg_front.sv
// Front part: accepts requests and classifies start requests over four stages.
module lpg_front import lpg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  logic      mode,
	input  coord_t    x_start,
	input  coord_t    y_start,
	input  coord_t    x_end,
	input  coord_t    y_end,
	input  color_t    line_color,
	output logic      cmd_valid,
	input  logic      cmd_ready,
	output lpg_cmd_t  cmd
);

	logic   en;
	logic   valid_s1, valid_s2, valid_s3, valid_s4;

	// Stage 1: raw endpoints and signed distances.
	logic   mode_s1;
	coord_t xa_s1, ya_s1, xb_s1, yb_s1;
	color_t color_s1;
	delta_t dx_s1, dy_s1;

	// Stage 2: magnitudes and directions.
	logic   mode_s2;
	coord_t xa_s2, ya_s2, xb_s2, yb_s2;
	color_t color_s2;
	dist_t  adx_s2, ady_s2;
	logic   dx_neg_s2, dy_neg_s2, dx_pos_s2, dy_pos_s2;

	// Stage 3: axis choice and endpoint ordering.
	logic   mode_s3;
	logic   steep_s3, minor_neg_s3;
	coord_t ma_s3, mb_s3, na_s3;
	dist_t  dmaj_s3, dmin_s3;
	color_t color_s3;

	// Stage 4: finished command.
	lpg_cmd_t cmd_s4;

	// Stage 3 selection terms.
	logic   steep_c, maj_neg_c;
	coord_t maj_a_c, maj_b_c, min_a_c, min_b_c;

	// Stage 4 arithmetic terms.
	err_t   dmin2_c, dmaj_c;

	// The whole pipeline holds while the last stage waits on a full queue.
	assign en        = !valid_s4 || cmd_ready;
	assign req_ready = en;
	assign cmd_valid = valid_s4;
	assign cmd       = cmd_s4;

	assign steep_c   = !(ady_s2 < adx_s2);
	assign maj_neg_c = steep_c ? dy_neg_s2 : dx_neg_s2;
	assign maj_a_c   = steep_c ? ya_s2 : xa_s2;
	assign maj_b_c   = steep_c ? yb_s2 : xb_s2;
	assign min_a_c   = steep_c ? xa_s2 : ya_s2;
	assign min_b_c   = steep_c ? xb_s2 : yb_s2;

	assign dmin2_c = err_t'({{(ERR_BITS-DELTA_BITS-1){1'b0}}, dmin_s3, 1'b0});
	assign dmaj_c  = err_t'({{(ERR_BITS-DELTA_BITS){1'b0}}, dmaj_s3});

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= req_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1  <= mode;
			xa_s1    <= x_start;
			ya_s1    <= y_start;
			xb_s1    <= x_end;
			yb_s1    <= y_end;
			color_s1 <= line_color;
			dx_s1    <= delta_t'({x_end[COORD_BITS-1], x_end})
				- delta_t'({x_start[COORD_BITS-1], x_start});
			dy_s1    <= delta_t'({y_end[COORD_BITS-1], y_end})
				- delta_t'({y_start[COORD_BITS-1], y_start});

			mode_s2   <= mode_s1;
			xa_s2     <= xa_s1;
			ya_s2     <= ya_s1;
			xb_s2     <= xb_s1;
			yb_s2     <= yb_s1;
			color_s2  <= color_s1;
			adx_s2    <= dx_s1[DELTA_BITS-1] ? dist_t'(-dx_s1) : dist_t'(dx_s1);
			ady_s2    <= dy_s1[DELTA_BITS-1] ? dist_t'(-dy_s1) : dist_t'(dy_s1);
			dx_neg_s2 <= dx_s1[DELTA_BITS-1];
			dy_neg_s2 <= dy_s1[DELTA_BITS-1];
			dx_pos_s2 <= !dx_s1[DELTA_BITS-1] && (dx_s1 != '0);
			dy_pos_s2 <= !dy_s1[DELTA_BITS-1] && (dy_s1 != '0);

			// Swap the endpoints when the major axis runs backwards.
			mode_s3      <= mode_s2;
			steep_s3     <= steep_c;
			ma_s3        <= maj_neg_c ? maj_b_c : maj_a_c;
			mb_s3        <= maj_neg_c ? maj_a_c : maj_b_c;
			na_s3        <= maj_neg_c ? min_b_c : min_a_c;
			dmaj_s3      <= steep_c ? ady_s2 : adx_s2;
			dmin_s3      <= steep_c ? adx_s2 : ady_s2;
			minor_neg_s3 <= steep_c
				? (maj_neg_c ? dx_pos_s2 : dx_neg_s2)
				: (maj_neg_c ? dy_pos_s2 : dy_neg_s2);
			color_s3     <= color_s2;

			cmd_s4.start        <= (mode_s3 == MODE_START);
			cmd_s4.steep        <= steep_s3;
			cmd_s4.minor_neg    <= minor_neg_s3;
			cmd_s4.major_pos    <= ma_s3;
			cmd_s4.major_stop   <= mb_s3;
			cmd_s4.minor_pos    <= na_s3;
			cmd_s4.error_term   <= dmin2_c - dmaj_c;
			cmd_s4.inc_straight <= dmin2_c;
			cmd_s4.inc_diagonal <= dmin2_c - (dmaj_c <<< 1);
			cmd_s4.color        <= color_s3;
		end
	end

endmodule

FILE: rtl/lpg_queue.sv
// Short command queue between the front and the back.
module lpg_queue import lpg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_valid,
	output logic      wr_ready,
	input  lpg_cmd_t  wr_cmd,
	output logic      rd_valid,
	input  logic      rd_ready,
	output lpg_cmd_t  rd_cmd
);

	lpg_cmd_t               entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0]   count_q;
	logic                   push, pop;

	assign wr_ready = (count_q != QCNT_BITS'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = entry_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

FILE: rtl/lpg_back.sv
// Back part: steps the line and drives the pixel output register.
module lpg_back import lpg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_ready,
	input  lpg_cmd_t cmd,
	output logic     pixel_valid,
	input  logic     pixel_ready,
	output coord_t   pixel_x,
	output coord_t   pixel_y,
	output color_t   pixel_color,
	output logic     last_pixel
);

	// Line state.
	logic   active_q, steep_q, minor_neg_q;
	coord_t major_pos_q, major_stop_q, minor_pos_q;
	err_t   error_term_q, inc_straight_q, inc_diagonal_q;
	color_t held_color_q;

	// Output register.
	logic   out_valid_q, last_q;
	coord_t px_q, py_q;
	color_t color_q;

	// Current line values, from a start command or from the held state.
	logic   pop, emit, is_start, last_c, step_minor;
	logic   cur_steep, cur_neg;
	coord_t cur_major, cur_stop, cur_minor;
	err_t   cur_err, cur_inc_s, cur_inc_d;
	color_t cur_color;

	assign cmd_ready = !out_valid_q || pixel_ready;
	assign pop       = cmd_valid && cmd_ready;
	assign is_start  = cmd.start;
	assign emit      = pop && (is_start || active_q);

	assign cur_steep = is_start ? cmd.steep        : steep_q;
	assign cur_neg   = is_start ? cmd.minor_neg    : minor_neg_q;
	assign cur_major = is_start ? cmd.major_pos    : major_pos_q;
	assign cur_stop  = is_start ? cmd.major_stop   : major_stop_q;
	assign cur_minor = is_start ? cmd.minor_pos    : minor_pos_q;
	assign cur_err   = is_start ? cmd.error_term   : error_term_q;
	assign cur_inc_s = is_start ? cmd.inc_straight : inc_straight_q;
	assign cur_inc_d = is_start ? cmd.inc_diagonal : inc_diagonal_q;
	assign cur_color = is_start ? cmd.color        : held_color_q;

	assign last_c     = (cur_major == cur_stop);
	assign step_minor = (cur_err > 0);

	assign pixel_valid = out_valid_q;
	assign pixel_x     = px_q;
	assign pixel_y     = py_q;
	assign pixel_color = color_q;
	assign last_pixel  = last_q;

	// Control state: line activity and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_ready) begin
				out_valid_q <= emit;
			end
			if (emit) begin
				active_q <= !last_c;
			end
		end
	end

	// Pixel word and the step to the next point of the line.
	always_ff @(posedge clk) begin
		if (emit) begin
			px_q    <= cur_steep ? cur_minor : cur_major;
			py_q    <= cur_steep ? cur_major : cur_minor;
			color_q <= cur_color;
			last_q  <= last_c;

			steep_q        <= cur_steep;
			minor_neg_q    <= cur_neg;
			major_stop_q   <= cur_stop;
			inc_straight_q <= cur_inc_s;
			inc_diagonal_q <= cur_inc_d;
			held_color_q   <= cur_color;
			major_pos_q    <= cur_major + coord_t'(1);
			if (step_minor) begin
				minor_pos_q  <= cur_neg ? cur_minor - coord_t'(1) : cur_minor + coord_t'(1);
				error_term_q <= cur_err + cur_inc_d;
			end else begin
				minor_pos_q  <= cur_minor;
				error_term_q <= cur_err + cur_inc_s;
			end
		end
	end

endmodule

FILE: rtl/line_pixel_generator.sv
// Line pixel generator top level: front, command queue and back.
//
// A request with mode start loads two endpoints and a colour and yields the
// first pixel of the line; each advance request yields the next pixel. The
// final pixel carries last_pixel. An advance request with no line in progress
// yields nothing, and a start request drops any line still in progress.
//
// Both channels use valid and ready; a request or a pixel moves on a clock
// edge where both are high. After its request is accepted, a pixel passes
// four front stages, one queue entry, then the output register. While the
// receiver takes pixels, requests are taken at one per cycle and pixels
// leave at one per cycle; the rate is set by the back, which does one add
// and compare per pixel.
// When the pixel receiver stalls, the output register holds its pixel, the
// back stops draining the queue, and the front keeps accepting requests until
// the queue is full and its fourth stage holds a request; then req_ready
// falls and all four front stages hold.
//
// Reset clears all valid bits, empties the queue and leaves no line active.
module line_pixel_generator import lpg_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   req_valid,
	output logic   req_ready,
	input  logic   mode,
	input  coord_t x_start,
	input  coord_t y_start,
	input  coord_t x_end,
	input  coord_t y_end,
	input  color_t line_color,
	output logic   pixel_valid,
	input  logic   pixel_ready,
	output coord_t pixel_x,
	output coord_t pixel_y,
	output color_t pixel_color,
	output logic   last_pixel
);

	logic      front_valid, front_ready;
	lpg_cmd_t  front_cmd;
	lpg_cmd_t  back_cmd;
	logic      back_valid, back_ready;

	lpg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.mode       (mode),
		.x_start    (x_start),
		.y_start    (y_start),
		.x_end      (x_end),
		.y_end      (y_end),
		.line_color (line_color),
		.cmd_valid  (front_valid),
		.cmd_ready  (front_ready),
		.cmd        (front_cmd)
	);

	lpg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_valid   (front_valid),
		.wr_ready   (front_ready),
		.wr_cmd     (front_cmd),
		.rd_valid   (back_valid),
		.rd_ready   (back_ready),
		.rd_cmd     (back_cmd)
	);

	lpg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (back_valid),
		.cmd_ready   (back_ready),
		.cmd         (back_cmd),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last_pixel  (last_pixel)
	);

endmodule
